### sv/tcrt_pkg.sv
`default_nettype none
package tcrt_pkg;

    localparam int KIND_W = 2;
    localparam int INDEX_W = 10;
    localparam int LENGTH_W = 11;
    localparam int CFG_IDX_W = 1;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0] t_op;

    localparam t_kind KIND_LOAD = 2'd0;
    localparam t_kind KIND_RUN = 2'd1;
    localparam t_kind KIND_READ = 2'd2;

    localparam t_cfg_idx REG_MODULUS = 1'd0;
    localparam t_cfg_idx REG_LENGTH = 1'd1;

    // Element operations of the sequencer.
    localparam t_op OP_FWD = 2'd0;
    localparam t_op OP_BK1 = 2'd1;
    localparam t_op OP_BK2 = 2'd2;

endpackage
`default_nettype wire

### sv/tcrt_alu.sv
`default_nettype none
module tcrt_alu #(
    parameter int WORD_BITS = 60
) (
    input  tcrt_pkg::t_op        i_op,
    input  wire [WORD_BITS-1:0]  i_mod,
    input  wire [WORD_BITS-1:0]  i_ra,
    input  wire [WORD_BITS-1:0]  i_rb,
    input  wire [WORD_BITS-1:0]  i_t,
    input  wire [WORD_BITS-1:0]  i_s,
    output logic [WORD_BITS-1:0] o_t,
    output logic [WORD_BITS-1:0] o_w
);
    import tcrt_pkg::*;

    localparam int W = WORD_BITS;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
        logic [W:0] s;
        logic [W:0] d;
        s = {1'b0, u} + {1'b0, v};
        d = s - {1'b0, p};
        f_add = (s >= {1'b0, p}) ? d[W-1:0] : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
        logic [W-1:0] d;
        d = u - v;
        f_sub = (u < v) ? d + p : d;
    endfunction

    function automatic logic [W-1:0] f_halve(input logic [W-1:0] s, input logic [W-1:0] p);
        logic [W:0] a;
        a = {1'b0, s} + {1'b0, p};
        f_halve = s[0] ? a[W:1] : {1'b0, s[W-1:1]};
    endfunction

    always_comb begin
        case (i_op)
            OP_FWD:  o_t = f_add(i_ra, i_rb, i_mod);
            OP_BK1:  o_t = f_add(i_rb, i_rb, i_mod);
            default: o_t = i_ra;
        endcase
    end

    always_comb begin
        case (i_op)
            OP_FWD:  o_w = f_halve(i_t, i_mod);
            OP_BK1:  o_w = f_sub(i_s, i_t, i_mod);
            default: o_w = f_sub(i_t, i_s, i_mod);
        endcase
    end

endmodule
`default_nettype wire

### sv/tft_transposed_crt_mod_p.sv
`default_nettype none
// A load is written into the vector store when accepted; a read latches the stored word
// and shows its beat from state RDOUT. A transform walks the stores one element step at
// a time through states ERD, EAD and EWR. There are fewer than 3*N element steps, none
// when N is a power of two, and the sequencer handles one element at a time.
// One item is in work at a time; a new one is taken once the result slot is free.
// Reset (synchronous, active low) restores modulus 3 and length 1; stores are undefined.
module tft_transposed_crt_mod_p #(
    parameter int MAX_LEN = 1024,
    parameter int WORD_BITS = 60
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  tcrt_pkg::t_kind                  i_kind,
    input  tcrt_pkg::t_index                 i_index,
    input  wire [WORD_BITS-1:0]              i_value,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [WORD_BITS-1:0]             o_data,
    output logic                             o_done_res,
    input  wire                              i_cfg_we,
    input  tcrt_pkg::t_cfg_idx               i_cfg_idx,
    input  wire [((WORD_BITS > 11) ? WORD_BITS : 11)-1:0] i_cfg_data
);
    import tcrt_pkg::*;

    localparam int W = WORD_BITS;
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDOUT = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_FSET  = 4'd3;
    localparam logic [3:0] S_BSET  = 4'd4;
    localparam logic [3:0] S_ERD   = 4'd5;
    localparam logic [3:0] S_EAD   = 4'd6;
    localparam logic [3:0] S_EWR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    function automatic logic [LW-1:0] f_hibit(input logic [LW-1:0] x);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < LW; i++) begin
            if (x[i]) begin
                r = '0;
                r[i] = 1'b1;
            end
        end
        f_hibit = r;
    endfunction

    logic [W-1:0]        r_mod;
    logic [LENGTH_W-1:0] r_len;
    logic [3:0]          r_state;
    t_op                 r_op;
    logic [LW-1:0]       r_total, r_rem, r_hi, r_lo, r_span, r_base, r_sbase, r_j, r_cnt;
    logic [W-1:0]        r_t, r_s;
    logic                r_oor;
    logic                r_ovalid;
    logic [W-1:0]        r_odata;
    logic                r_odone;

    logic [W-1:0] vmem [MAX_LEN];
    logic [W-1:0] smem [MAX_LEN];
    logic [W-1:0] r_ra, r_rb, r_rs;

    logic [AW-1:0] va, vb, sa, vwa, swa;
    logic          vwe, swe;
    logic [W-1:0]  vwd;
    logic [W-1:0]  alu_t, alu_w;
    logic [31:0]   idx_wide;
    logic          in_range;
    logic          accept;
    logic [LW-1:0] total_n, rem_n, h2, hn, j_last;
    logic [LW-1:0] a_fa, a_fb, a_sj, a_slj, a_sk;

    assign idx_wide = 32'(i_index);
    assign in_range = idx_wide < 32'(MAX_LEN);
    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign accept = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_data = r_odata;
    assign o_done_res = r_odone;

    assign total_n = (32'(r_len) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(r_len);
    assign rem_n = r_rem - r_hi;
    assign h2 = r_hi << 1;
    assign hn = (r_total & ~(h2 - 1'b1)) & (~(r_total & ~(h2 - 1'b1)) + 1'b1);
    assign j_last = r_cnt - 1'b1;

    assign a_fa = r_base + r_j;
    assign a_fb = r_base + r_hi + r_j;
    assign a_sj = r_sbase + r_j;
    assign a_slj = r_sbase + r_lo + r_j;
    assign a_sk = r_sbase + (r_j & (r_span - 1'b1));

    always_comb begin
        va = a_fa[AW-1:0];
        vb = a_fb[AW-1:0];
        sa = a_sj[AW-1:0];
        vwa = a_fb[AW-1:0];
        swa = a_sj[AW-1:0];
        vwd = alu_w;
        vwe = 1'b0;
        swe = 1'b0;
        if (r_state == S_IDLE) begin
            va = idx_wide[AW-1:0];
            vwa = idx_wide[AW-1:0];
            vwd = i_value;
            vwe = accept && (i_kind == KIND_LOAD) && in_range;
        end else begin
            case (r_op)
                OP_BK1: swa = a_slj[AW-1:0];
                OP_BK2: begin
                    sa = a_sk[AW-1:0];
                    vwa = a_fa[AW-1:0];
                end
                default: ;
            endcase
            if (r_state == S_EWR) begin
                vwe = (r_op != OP_BK1);
                swe = (r_op == OP_BK1) || ((r_op == OP_FWD) && (r_j < r_lo));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            vmem[vwa] <= vwd;
        end
        if (swe) begin
            smem[swa] <= alu_w;
        end
        r_ra <= vmem[va];
        r_rb <= vmem[vb];
        r_rs <= smem[sa];
    end

    tcrt_alu #(.WORD_BITS(W)) u_alu (
        .i_op  (r_op),
        .i_mod (r_mod),
        .i_ra  (r_ra),
        .i_rb  (r_rb),
        .i_t   (r_t),
        .i_s   (r_s),
        .o_t   (alu_t),
        .o_w   (alu_w)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_EAD) begin
            r_t <= alu_t;
            r_s <= r_rs;
        end
        if (accept) begin
            r_oor <= !in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(3);
            r_len <= LENGTH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODULUS: r_mod <= i_cfg_data[W-1:0];
                REG_LENGTH:  r_len <= i_cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_op <= OP_FWD;
            r_odata <= '0;
            r_odone <= 1'b0;
            r_total <= '0;
            r_rem <= '0;
            r_hi <= '0;
            r_lo <= '0;
            r_span <= '0;
            r_base <= '0;
            r_sbase <= '0;
            r_j <= '0;
            r_cnt <= '0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_kind == KIND_RUN) begin
                            r_state <= S_START;
                        end else if (i_kind == KIND_READ) begin
                            r_state <= S_RDOUT;
                        end
                    end
                end
                S_RDOUT: begin
                    r_ovalid <= 1'b1;
                    r_odata <= r_oor ? '0 : r_ra;
                    r_odone <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_START: begin
                    r_total <= total_n;
                    r_rem <= total_n;
                    r_hi <= f_hibit(total_n);
                    r_base <= '0;
                    r_sbase <= '0;
                    r_state <= (total_n <= LW'(1)) ? S_DONE : S_FSET;
                end
                S_FSET: begin
                    if (r_rem == r_hi) begin
                        r_state <= S_BSET;
                    end else begin
                        r_rem <= rem_n;
                        r_lo <= f_hibit(rem_n);
                        r_cnt <= rem_n;
                        r_j <= '0;
                        r_op <= OP_FWD;
                        r_state <= S_ERD;
                    end
                end
                S_BSET: begin
                    if (r_rem == r_total) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lo <= r_hi;
                        r_cnt <= r_hi;
                        r_hi <= hn;
                        r_span <= h2;
                        r_sbase <= r_sbase - h2;
                        r_base <= r_base - hn;
                        r_j <= '0;
                        r_op <= OP_BK1;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: r_state <= S_EAD;
                S_EAD: r_state <= S_EWR;
                S_EWR: begin
                    if (r_j == j_last) begin
                        r_j <= '0;
                        case (r_op)
                            OP_FWD: begin
                                r_sbase <= r_sbase + (r_lo << 1);
                                r_base <= r_base + r_hi;
                                r_hi <= r_lo;
                                r_state <= S_FSET;
                            end
                            OP_BK1: begin
                                // Second half of a backward block runs over all of hi.
                                r_op <= OP_BK2;
                                r_cnt <= r_hi;
                                r_state <= S_ERD;
                            end
                            default: begin
                                r_rem <= r_rem + r_hi;
                                r_state <= S_BSET;
                            end
                        endcase
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_odata <= '0;
                    r_odone <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### sim/tcrt_checker.sv
`default_nettype none
module tcrt_checker #(
    parameter int MAX_LEN = 1024,
    parameter int WORD_BITS = 60
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   i_ready_in,
    input  tcrt_pkg::t_kind       i_kind,
    input  tcrt_pkg::t_index      i_index,
    input  wire [WORD_BITS-1:0]   i_value,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  wire [WORD_BITS-1:0]   i_data,
    input  wire                   i_done_res,
    input  wire                   i_cfg_we,
    input  tcrt_pkg::t_cfg_idx    i_cfg_idx,
    input  wire [WORD_BITS-1:0]   i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    import tcrt_pkg::*;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef struct packed {
        t_word data;
        logic  done;
    } t_beat;

    t_word  vec_mem [MAX_LEN];
    t_word  scr_mem [MAX_LEN];
    t_word  mod_p;
    logic [LENGTH_W-1:0] vec_len;
    t_beat  pending_beats [$];
    int     fail_cnt;

    assign o_fail_count = fail_cnt;

    function automatic t_word mod_add(t_word u, t_word v);
        logic [63:0] s;
        s = {4'd0, u} + {4'd0, v};
        if (s >= {4'd0, mod_p}) s = s - {4'd0, mod_p};
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_word mod_sub(t_word u, t_word v);
        logic [63:0] d;
        d = {4'd0, u} - {4'd0, v};
        if (u < v) d = d + {4'd0, mod_p};
        return d[WORD_BITS-1:0];
    endfunction

    function automatic t_word mod_half(t_word s);
        logic [63:0] t;
        t = {4'd0, s};
        if (s[0]) t = t + {4'd0, mod_p};
        t = t >> 1;
        return t[WORD_BITS-1:0];
    endfunction

    task automatic fold_vector();
        int unsigned total, rest, hi, lo, span, base, sbase, j, k;
        t_word w, up;
        total = (vec_len > MAX_LEN) ? MAX_LEN : vec_len;
        if (total <= 1) return;
        rest = total;
        hi = 1;
        while (hi <= (rest >> 1)) hi = hi << 1;
        base = 0;
        sbase = 0;
        // Forward pass: peel off the powers of two, largest first.
        while (rest != hi) begin
            rest = rest - hi;
            lo = 1;
            while (lo <= (rest >> 1)) lo = lo << 1;
            for (j = 0; j < rest; j++) begin
                w = mod_half(mod_add(vec_mem[base + j], vec_mem[base + hi + j]));
                vec_mem[base + hi + j] = w;
                if (j < lo) scr_mem[sbase + j] = w;
            end
            sbase = sbase + (lo << 1);
            base = base + hi;
            hi = lo;
        end
        // Backward pass: fold the saved copies back into the lower blocks.
        while (rest != total) begin
            lo = hi;
            hi = hi << 1;
            span = hi;
            while ((hi & total) == 0) hi = hi << 1;
            sbase = sbase - span;
            base = base - hi;
            for (j = 0; j < lo; j++) begin
                up = vec_mem[base + hi + j];
                scr_mem[sbase + lo + j] = mod_sub(scr_mem[sbase + j], mod_add(up, up));
            end
            for (k = 0; k < hi; k++)
                vec_mem[base + k] = mod_sub(vec_mem[base + k], scr_mem[sbase + (k & (span - 1))]);
            rest = rest + hi;
        end
    endtask

    initial begin
        fail_cnt = 0;
        o_pending = 0;
        mod_p = t_word'(3);
        vec_len = LENGTH_W'(1);
        foreach (vec_mem[i]) begin
            vec_mem[i] = '0;
            scr_mem[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            mod_p = t_word'(3);
            vec_len = LENGTH_W'(1);
            pending_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODULUS: mod_p = i_cfg_data;
                    REG_LENGTH: vec_len = i_cfg_data[LENGTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_beats.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected output beat: data %h done %b", i_data, i_done_res);
                end else begin
                    want = pending_beats.pop_front();
                    if (i_data !== want.data || i_done_res !== want.done) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: data %h done %b, expected data %h done %b",
                                     i_data, i_done_res, want.data, want.done);
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                case (i_kind)
                    KIND_LOAD: vec_mem[i_index] = i_value;
                    KIND_RUN: begin
                        fold_vector();
                        pending_beats.push_back('{data: '0, done: 1'b1});
                    end
                    KIND_READ: pending_beats.push_back('{data: vec_mem[i_index], done: 1'b0});
                    default: ;
                endcase
            end
        end
        o_pending = pending_beats.size();
    end

endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
    import tcrt_pkg::*;

    localparam int MAX_LEN = 1024;
    localparam int WORD_BITS = 60;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [WORD_BITS-1:0] TOP_MOD = {WORD_BITS{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_kind                i_kind;
    t_index               i_index;
    logic [WORD_BITS-1:0] i_value;
    logic                 o_valid;
    logic                 i_ready;
    logic [WORD_BITS-1:0] o_data;
    logic                 o_done_res;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [WORD_BITS-1:0] i_cfg_data;
    int                   fail_count;
    int                   pending;

    // Shared between the sender, the receiver and the watchdog.
    bit                   calm;
    int                   hold_cycles;
    bit                   gap_next;
    logic [WORD_BITS-1:0] cur_mod;
    int                   cur_len;
    bit                   loaded [MAX_LEN];
    int                   cycles;

    tft_transposed_crt_mod_p #(.MAX_LEN(MAX_LEN), .WORD_BITS(WORD_BITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_index(i_index), .i_value(i_value),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data), .o_done_res(o_done_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    tcrt_checker #(.MAX_LEN(MAX_LEN), .WORD_BITS(WORD_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_kind(i_kind), .i_index(i_index), .i_value(i_value),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_data(o_data),
        .i_done_res(o_done_res), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_word();
        return WORD_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_residue();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return cur_mod - 1;
        return rand_word() % cur_mod;
    endfunction

    task automatic send(t_kind kind, int idx, logic [WORD_BITS-1:0] val);
        if (gap_next) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_index <= idx[INDEX_W-1:0];
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Keep valid up for a back-to-back beat unless a gap follows.
        gap_next = !calm && ($urandom_range(99) < 24);
        if (gap_next) i_valid <= 1'b0;
        if (kind == KIND_LOAD) loaded[idx] = 1'b1;
    endtask

    task automatic drain();
        if (!gap_next) i_valid <= 1'b0;
        gap_next = 1'b1;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Loads give no beat, so after draining, wait before reconfiguring.
    task automatic configure(logic [WORD_BITS-1:0] modv, int len);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_MODULUS;
        i_cfg_data <= modv;
        @(posedge i_clk);
        i_cfg_idx <= REG_LENGTH;
        i_cfg_data <= WORD_BITS'(len);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mod = modv;
        cur_len = len > MAX_LEN ? MAX_LEN : len;
    endtask

    // Long vectors only load the elements that were never written before.
    task automatic fill_vector();
        for (int i = 0; i < cur_len; i++)
            if (cur_len <= 64 || !loaded[i]) send(KIND_LOAD, i, rand_residue());
    endtask

    task automatic read_some();
        int idx;
        idx = $urandom_range(MAX_LEN - 1);
        while (!loaded[idx]) idx = $urandom_range(MAX_LEN - 1);
        send(KIND_READ, idx, rand_word());
    endtask

    task automatic random_ops(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) send(KIND_LOAD, $urandom_range(cur_len - 1), rand_residue());
            else if (pick < 85) read_some();
            else if (pick < 97) send(KIND_RUN, $urandom_range(MAX_LEN - 1), rand_word());
            else send(t_kind'(3), $urandom_range(MAX_LEN - 1), rand_word());
        end
    endtask

    initial begin
        int lens [8];
        logic [WORD_BITS-1:0] mods [4];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_index = '0;
        i_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MODULUS;
        i_cfg_data = '0;
        calm = 1'b0;
        hold_cycles = 0;
        gap_next = 1'b1;
        cur_mod = 3;
        cur_len = 1;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then a split length at the widest modulus.
        send(KIND_LOAD, 0, 2);
        send(KIND_RUN, 0, 0);
        send(KIND_READ, 0, 0);
        configure(TOP_MOD, 5);
        send(KIND_LOAD, 0, '0);
        send(KIND_LOAD, 1, TOP_MOD - 1);
        send(KIND_LOAD, 2, TOP_MOD - 1);
        send(KIND_LOAD, 3, 1);
        send(KIND_LOAD, 4, TOP_MOD - 2);
        send(KIND_RUN, 0, 0);
        for (int i = 0; i < 5; i++) send(KIND_READ, i, 0);
        send(t_kind'(3), 1, TOP_MOD);
        send(KIND_READ, 1, 0);
        configure(7, 0);
        send(KIND_RUN, 0, 0);
        send(KIND_READ, 4, 0);
        configure(3, 3);
        fill_vector();
        send(KIND_RUN, 0, 0);
        send(KIND_READ, 2, 0);

        // Random phases; the largest length (given above the limit) only once.
        lens = '{2, 7, 13, 2047, 31, 1, 24, 40};
        mods = '{3, TOP_MOD, 1000003, 60'd1152921504606846883};
        for (int ph = 0; ph < 10; ph++) begin
            logic [WORD_BITS-1:0] m;
            int len;
            m = (ph % 5 == 4) ? (rand_word() | 1) : mods[$urandom_range(3)];
            if (m < 3) m = 3;
            len = (ph < 8) ? lens[ph] : $urandom_range(1, 40);
            configure(m, len);
            calm = (ph == 5);
            fill_vector();
            send(KIND_RUN, 0, 0);
            if (ph == 6) begin
                hold_cycles = 400;
                for (int n = 0; n < 20; n++) read_some();
            end
            random_ops(len > 100 ? 0 : 8);
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
sv/tcrt_pkg.sv
sv/tcrt_alu.sv
sv/tft_transposed_crt_mod_p.sv
sim/tcrt_checker.sv
sim/testbench.sv
